// ===== rtl/core/wbit_pkg.sv =====
// Shared types, codes and constants of the work/break interval timer.
`timescale 1ns / 1ps

package wbit_pkg;

   localparam int TIME_W      = 48;
   localparam int DUR_W       = 27;
   localparam int MIN_W       = 11;
   localparam int SEC_W       = 6;
   localparam int SLOT_W      = 3;
   localparam int KIND_W      = 2;
   localparam int STATUS_W    = 2;
   localparam int COUNT_W     = 16;
   localparam int CSR_IDX_W   = 2;

   localparam logic [DUR_W-1:0] WORK_RESET  = 27'd1500000;
   localparam logic [DUR_W-1:0] SHORT_RESET = 27'd300000;
   localparam logic [DUR_W-1:0] LONG_RESET  = 27'd900000;

   localparam logic [CSR_IDX_W-1:0] CSR_WORK  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SHORT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG  = 2'd2;

   typedef enum logic [1:0] {
      FUNC_TICK,
      FUNC_TOGGLE,
      FUNC_RESET,
      FUNC_SKIP
   } func_type;

   typedef logic [KIND_W-1:0]   kind_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam kind_type KIND_WORK  = 2'd0;
   localparam kind_type KIND_SHORT = 2'd1;
   localparam kind_type KIND_LONG  = 2'd2;

   localparam status_type STATUS_READY  = 2'd0;
   localparam status_type STATUS_RUN    = 2'd1;
   localparam status_type STATUS_PAUSED = 2'd2;

   // ceil(ms / 1000) through a reciprocal multiply, then / 60 the same way
   localparam int RND_W       = DUR_W + 1;
   localparam logic [RND_W-1:0] CEIL_ADD = 28'd999;
   localparam int RECIP1_W    = 29;
   localparam logic [RECIP1_W-1:0] RECIP_1000 = 29'd274877907;
   localparam int SHIFT_1000  = 38;
   localparam int PROD1_W     = RND_W + RECIP1_W;
   localparam int SECS_W      = 18;
   localparam int RECIP2_W    = 19;
   localparam logic [RECIP2_W-1:0] RECIP_60 = 19'd279621;
   localparam int SHIFT_60    = 24;
   localparam int PROD2_W     = SECS_W + RECIP2_W;
   localparam int MINS_FULL_W = 12;
   localparam logic [SECS_W-1:0] SECS_PER_MIN = 18'd60;
   localparam logic [MIN_W-1:0]  MIN_MAX      = 11'd2047;

   typedef struct packed {
      func_type           func;
      logic [TIME_W-1:0]  now_ms;
   } wbit_req_type;

   typedef struct packed {
      logic [MIN_W-1:0]   minutes_left;
      logic [SEC_W-1:0]   seconds_left;
      logic [SLOT_W-1:0]  slot_index;
      kind_type           slot_kind;
      status_type         run_status;
      logic [COUNT_W-1:0] done_count;
      logic               expired;
   } wbit_rsp_type;

   typedef struct packed {
      logic [SLOT_W-1:0]  slot_index;
      kind_type           slot_kind;
      status_type         run_status;
      logic [COUNT_W-1:0] done_count;
      logic               expired;
   } wbit_side_type;

endpackage

// ===== rtl/core/wbit_if.sv =====
// Request and response stream interfaces of the interval timer.
`timescale 1ns / 1ps

interface wbit_req_if;
   import wbit_pkg::*;

   logic         valid;
   logic         ready;
   wbit_req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface wbit_rsp_if;
   import wbit_pkg::*;

   logic         valid;
   logic         ready;
   wbit_rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/wbit_time_split.sv =====
// Remaining milliseconds to rounded-up minutes and seconds, three register stages.
`timescale 1ns / 1ps

module wbit_time_split import wbit_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [DUR_W-1:0]   in_left,
   input  wbit_side_type      in_side,
   output logic               out_valid,
   input  logic               out_ready,
   output wbit_rsp_type       out_rsp
);

   logic                   a_valid_ff;
   logic                   b_valid_ff;
   logic                   c_valid_ff;
   logic                   a_load;
   logic                   b_load;
   logic                   c_load;
   logic [RND_W-1:0]       rounded;
   logic [PROD1_W-1:0]     a_prod_ff;
   logic [PROD1_W-1:0]     a_prod_in;
   wbit_side_type          a_side_ff;
   logic [SECS_W-1:0]      b_secs_ff;
   logic [SECS_W-1:0]      b_secs_in;
   logic [PROD2_W-1:0]     b_prod_ff;
   logic [PROD2_W-1:0]     b_prod_in;
   wbit_side_type          b_side_ff;
   logic [MINS_FULL_W-1:0] mins_full;
   logic [SECS_W-1:0]      min_secs;
   wbit_rsp_type           c_rsp_ff;
   wbit_rsp_type           c_rsp_in;

   assign c_load   = !c_valid_ff || out_ready;
   assign b_load   = !b_valid_ff || c_load;
   assign a_load   = !a_valid_ff || b_load;
   assign in_ready = a_load;

   always_comb begin
      rounded   = RND_W'(in_left) + CEIL_ADD;
      a_prod_in = PROD1_W'(rounded) * PROD1_W'(RECIP_1000);
      b_secs_in = a_prod_ff[SHIFT_1000 +: SECS_W];
      b_prod_in = PROD2_W'(b_secs_in) * PROD2_W'(RECIP_60);
      mins_full = b_prod_ff[SHIFT_60 +: MINS_FULL_W];
      min_secs  = SECS_W'(mins_full) * SECS_PER_MIN;

      c_rsp_in.minutes_left = (mins_full > MINS_FULL_W'(MIN_MAX)) ? MIN_MAX
                                                                 : mins_full[MIN_W-1:0];
      c_rsp_in.seconds_left = SEC_W'(b_secs_ff - min_secs);
      c_rsp_in.slot_index   = b_side_ff.slot_index;
      c_rsp_in.slot_kind    = b_side_ff.slot_kind;
      c_rsp_in.run_status   = b_side_ff.run_status;
      c_rsp_in.done_count   = b_side_ff.done_count;
      c_rsp_in.expired      = b_side_ff.expired;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         if (a_load) begin
            a_valid_ff <= in_valid;
         end
         if (b_load) begin
            b_valid_ff <= a_valid_ff;
         end
         if (c_load) begin
            c_valid_ff <= b_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (a_load) begin
         a_prod_ff <= a_prod_in;
         a_side_ff <= in_side;
      end
      if (b_load) begin
         b_secs_ff <= b_secs_in;
         b_prod_ff <= b_prod_in;
         b_side_ff <= a_side_ff;
      end
      if (c_load) begin
         c_rsp_ff <= c_rsp_in;
      end
   end

   assign out_valid = c_valid_ff;
   assign out_rsp   = c_rsp_ff;

endmodule

// ===== rtl/core/work_break_interval_timer.sv =====
// Top level of the work/break interval timer.
`timescale 1ns / 1ps

// Takes one request per clock and returns exactly one response per request, in order.
// A request is registered, then executed against the timer state (slot, run flag, start
// stamp, banked time, completed count), which updates the state so the following request
// sees it. The remaining time then passes through a three-stage unit that forms
// ceil(ms / 1000) and the minute/second split by two reciprocal multiplies, one register
// after each. Throughput is one item per cycle, held back only by response stalls.
// Duration registers take effect for requests executed after the write; write them only
// while no request is in flight. There is no post-reset initialization sequence.
module work_break_interval_timer import wbit_pkg::*; #(
   parameter int SLOTS_PER_CYCLE = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   wbit_req_if.sink             req_if,
   wbit_rsp_if.source           rsp_if,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DUR_W-1:0]     csr_wdata
);

   localparam int SlotPosW = $clog2(SLOTS_PER_CYCLE);
   localparam logic [SlotPosW-1:0] LastSlot = SlotPosW'(SLOTS_PER_CYCLE - 1);

   logic [DUR_W-1:0]    work_ff;
   logic [DUR_W-1:0]    short_ff;
   logic [DUR_W-1:0]    long_ff;

   logic [SlotPosW-1:0] slot_ff;
   logic [SlotPosW-1:0] slot_in;
   logic                running_ff;
   logic                running_in;
   logic [TIME_W-1:0]   start_ff;
   logic [TIME_W-1:0]   start_in;
   logic [TIME_W-1:0]   banked_ff;
   logic [TIME_W-1:0]   banked_in;
   logic [COUNT_W-1:0]  count_ff;
   logic [COUNT_W-1:0]  count_in;

   logic                in_valid_ff;
   wbit_req_type        in_req_ff;
   logic                ex_valid_ff;
   logic [DUR_W-1:0]    ex_left_ff;
   logic [DUR_W-1:0]    ex_left_in;
   wbit_side_type       ex_side_ff;
   wbit_side_type       ex_side_in;

   logic                split_ready;
   logic                ex_load;
   logic                in_load;
   logic                exec_fire;

   logic [TIME_W-1:0]   since;
   logic [TIME_W:0]     sum_wide;
   logic [TIME_W-1:0]   run_spent;
   logic [TIME_W-1:0]   live_spent;
   logic [TIME_W-1:0]   spent;
   logic [SlotPosW-1:0] next_slot;
   logic [SlotPosW-1:0] out_slot;
   logic [COUNT_W-1:0]  out_count;
   logic                out_running;
   kind_type            out_kind;
   logic [DUR_W-1:0]    total;
   logic                over;
   logic                clamp_nz;
   logic                expire_now;

   assign ex_load       = !ex_valid_ff || split_ready;
   assign in_load       = !in_valid_ff || ex_load;
   assign exec_fire     = in_valid_ff && ex_load;
   assign req_if.ready  = in_load;

   always_comb begin
      slot_in     = slot_ff;
      running_in  = running_ff;
      start_in    = start_ff;
      banked_in   = banked_ff;
      count_in    = count_ff;

      since       = (in_req_ff.now_ms >= start_ff) ? (in_req_ff.now_ms - start_ff) : '0;
      sum_wide    = {1'b0, banked_ff} + {1'b0, since};
      run_spent   = sum_wide[TIME_W] ? '1 : sum_wide[TIME_W-1:0];
      live_spent  = running_ff ? run_spent : banked_ff;
      next_slot   = (slot_ff == LastSlot) ? '0 : slot_ff + 1'b1;

      spent       = live_spent;
      out_slot    = slot_ff;
      out_count   = count_ff;
      out_running = running_ff;

      unique case (in_req_ff.func)
         FUNC_TICK: begin
            out_running = running_ff;
         end
         FUNC_TOGGLE: begin
            out_running = !running_ff;
            if (running_ff) begin
               banked_in  = run_spent;
               running_in = 1'b0;
            end else begin
               start_in   = in_req_ff.now_ms;
               running_in = 1'b1;
            end
         end
         FUNC_RESET: begin
            spent       = '0;
            out_running = 1'b0;
            banked_in   = '0;
            running_in  = 1'b0;
            start_in    = '0;
         end
         FUNC_SKIP: begin
            spent       = '0;
            out_running = 1'b0;
            out_slot    = next_slot;
            out_count   = count_ff + 1'b1;
            slot_in     = next_slot;
            banked_in   = '0;
            running_in  = 1'b0;
            start_in    = '0;
            count_in    = count_ff + 1'b1;
         end
      endcase

      out_kind = (out_slot == LastSlot) ? KIND_LONG : KIND_W'(out_slot[0]);

      unique case (out_kind)
         KIND_WORK:  total = work_ff;
         KIND_SHORT: total = short_ff;
         default:    total = long_ff;
      endcase

      over       = spent >= TIME_W'(total);
      ex_left_in = over ? '0 : (total - spent[DUR_W-1:0]);
      clamp_nz   = over ? (total != '0) : (spent != '0);
      expire_now = (in_req_ff.func == FUNC_TICK) && running_ff && over;

      // advance after the readout of an expiring tick
      if (expire_now) begin
         slot_in    = next_slot;
         running_in = 1'b0;
         banked_in  = '0;
         start_in   = '0;
         count_in   = count_ff + 1'b1;
      end

      ex_side_in.slot_index = SLOT_W'(out_slot);
      ex_side_in.slot_kind  = out_kind;
      ex_side_in.run_status = out_running ? STATUS_RUN
                                          : (clamp_nz ? STATUS_PAUSED : STATUS_READY);
      ex_side_in.done_count = out_count;
      ex_side_in.expired    = expire_now;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_ff     <= WORK_RESET;
         short_ff    <= SHORT_RESET;
         long_ff     <= LONG_RESET;
         slot_ff     <= '0;
         running_ff  <= 1'b0;
         start_ff    <= '0;
         banked_ff   <= '0;
         count_ff    <= '0;
         in_valid_ff <= 1'b0;
         ex_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_WORK:  work_ff  <= csr_wdata;
               CSR_SHORT: short_ff <= csr_wdata;
               CSR_LONG:  long_ff  <= csr_wdata;
               default:   work_ff  <= work_ff;
            endcase
         end
         if (exec_fire) begin
            slot_ff    <= slot_in;
            running_ff <= running_in;
            start_ff   <= start_in;
            banked_ff  <= banked_in;
            count_ff   <= count_in;
         end
         if (in_load) begin
            in_valid_ff <= req_if.valid;
         end
         if (ex_load) begin
            ex_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         in_req_ff <= req_if.data;
      end
      if (ex_load) begin
         ex_left_ff <= ex_left_in;
         ex_side_ff <= ex_side_in;
      end
   end

   wbit_time_split u_time_split (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (ex_valid_ff),
      .in_ready  (split_ready),
      .in_left   (ex_left_ff),
      .in_side   (ex_side_ff),
      .out_valid (rsp_if.valid),
      .out_ready (rsp_if.ready),
      .out_rsp   (rsp_if.data)
   );

`ifndef SYNTHESIS
   a_expire_readout: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.data.expired |->
         rsp_if.data.minutes_left == '0 && rsp_if.data.seconds_left == '0 &&
         rsp_if.data.run_status == STATUS_RUN)
      else $error("expired response with time left or not running");

   a_secs_range: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> rsp_if.data.seconds_left < SEC_W'(SECS_PER_MIN))
      else $error("seconds field out of range");

   a_expire_clears: assert property (@(posedge clock) disable iff (reset)
      exec_fire && expire_now |=>
         !running_ff && banked_ff == '0 && count_ff == COUNT_W'($past(count_ff) + 1'b1))
      else $error("expiry did not stop, clear and count the interval");

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      slot_ff <= LastSlot)
      else $error("slot position beyond the last slot");
`endif

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench of the work/break interval timer: directed and random transfers.
`timescale 1ns / 1ps

module testbench;
   import wbit_pkg::*;

   localparam int SLOTS        = 8;
   localparam int CYCLE_LIMIT  = 100000;
   localparam int DRAIN_CYCLES = 8;
   localparam int HOLD_CYCLES  = 300;
   localparam int MAX_REPORTS  = 10;
   localparam int MS_PER_SEC   = 1000;
   localparam int SEC_PER_MIN  = 60;
   localparam logic [TIME_W-1:0]    TIME_MAX  = '1;
   localparam logic [DUR_W-1:0]     DUR_MAX   = '1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PERIODIC} stall_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [DUR_W-1:0]     csr_wdata;

   wbit_req_if req_ch();
   wbit_rsp_if rsp_ch();

   work_break_interval_timer #(.SLOTS_PER_CYCLE(SLOTS)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   logic [DUR_W-1:0]   work_ms        = WORK_RESET;
   logic [DUR_W-1:0]   short_ms       = SHORT_RESET;
   logic [DUR_W-1:0]   long_ms        = LONG_RESET;
   logic [SLOT_W-1:0]  slot_pos       = '0;
   logic               running        = 1'b0;
   logic [TIME_W-1:0]  start_ms       = '0;
   logic [TIME_W-1:0]  banked_ms      = '0;
   logic [COUNT_W-1:0] intervals_done = '0;

   wbit_rsp_type expected_readouts[$];
   int           mismatch_count = 0;
   int           cycle_count    = 0;
   int           hold_left      = 0;
   int           burst_left     = 0;
   bit           sender_gaps    = 1'b1;
   stall_type    stall_mode     = STALL_NONE;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** work_break_interval_timer: FAILED **");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else begin
         case (stall_mode)
            STALL_NONE:   rsp_ch.ready <= 1'b1;
            STALL_RANDOM: rsp_ch.ready <= ($urandom_range(0, 1) == 1);
            default:      rsp_ch.ready <= (cycle_count % 4 != 3);
         endcase
      end
      if (cycle_count % 64 == 0)
         stall_mode <= stall_type'($urandom_range(0, 2));
   end

   function automatic string show(input wbit_rsp_type r);
      return $sformatf("%0d:%02d slot %0d kind %0d status %0d count %0d expired %0d",
                       r.minutes_left, r.seconds_left, r.slot_index, r.slot_kind,
                       r.run_status, r.done_count, r.expired);
   endfunction

   function automatic void report_mismatch(input string what, input wbit_rsp_type want,
                                           input wbit_rsp_type got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("mismatch (%s) at cycle %0d: expected %s, got %s",
                  what, cycle_count, show(want), show(got));
   endfunction

   always @(posedge clock) begin : check_results
      wbit_rsp_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (expected_readouts.size() == 0) begin
            report_mismatch("unexpected transfer", '0, rsp_ch.data);
         end else begin
            want = expected_readouts.pop_front();
            if (rsp_ch.data.minutes_left !== want.minutes_left ||
                rsp_ch.data.seconds_left !== want.seconds_left ||
                rsp_ch.data.slot_index   !== want.slot_index   ||
                rsp_ch.data.slot_kind    !== want.slot_kind    ||
                rsp_ch.data.run_status   !== want.run_status   ||
                rsp_ch.data.done_count   !== want.done_count   ||
                rsp_ch.data.expired      !== want.expired)
               report_mismatch("readout", want, rsp_ch.data);
         end
      end
   end

   function automatic logic [TIME_W-1:0] add_saturated(input logic [TIME_W-1:0] a,
                                                       input logic [TIME_W-1:0] b);
      logic [TIME_W:0] total;
      total = a + b;
      return total[TIME_W] ? TIME_MAX : total[TIME_W-1:0];
   endfunction

   function automatic logic [TIME_W-1:0] elapsed_since_start(input logic [TIME_W-1:0] now);
      return (now >= start_ms) ? now - start_ms : '0;
   endfunction

   function automatic wbit_rsp_type timer_readout(input logic [TIME_W-1:0] now,
                                                  output bit time_up);
      kind_type          kind;
      logic [TIME_W-1:0] total;
      logic [TIME_W-1:0] spent;
      logic [TIME_W-1:0] left;
      logic [TIME_W-1:0] secs;
      logic [TIME_W-1:0] mins;
      wbit_rsp_type      r;
      if (slot_pos == SLOT_W'(SLOTS - 1))
         kind = KIND_LONG;
      else if (slot_pos[0])
         kind = KIND_SHORT;
      else
         kind = KIND_WORK;
      if (kind == KIND_WORK)
         total = TIME_W'(work_ms);
      else if (kind == KIND_SHORT)
         total = TIME_W'(short_ms);
      else
         total = TIME_W'(long_ms);
      spent = running ? add_saturated(banked_ms, elapsed_since_start(now)) : banked_ms;
      if (spent > total)
         spent = total;
      left = total - spent;
      secs = (left + MS_PER_SEC - 1) / MS_PER_SEC;
      mins = secs / SEC_PER_MIN;
      r.minutes_left = (mins > MIN_MAX) ? MIN_MAX : MIN_W'(mins);
      r.seconds_left = SEC_W'(secs % SEC_PER_MIN);
      r.slot_index   = slot_pos;
      r.slot_kind    = kind;
      if (running)
         r.run_status = STATUS_RUN;
      else if (spent != 0)
         r.run_status = STATUS_PAUSED;
      else
         r.run_status = STATUS_READY;
      r.done_count = intervals_done;
      r.expired    = 1'b0;
      time_up = (left == 0);
      return r;
   endfunction

   function automatic void next_interval();
      slot_pos       = (slot_pos == SLOT_W'(SLOTS - 1)) ? '0 : slot_pos + 1'b1;
      banked_ms      = '0;
      running        = 1'b0;
      start_ms       = '0;
      intervals_done = intervals_done + 1'b1;
   endfunction

   function automatic void apply_request(input func_type f, input logic [TIME_W-1:0] now);
      wbit_rsp_type r;
      bit           time_up;
      case (f)
         FUNC_TICK: begin
            r = timer_readout(now, time_up);
            if (time_up && running) begin
               next_interval();
               r.expired = 1'b1;
            end
         end
         FUNC_TOGGLE: begin
            if (running) begin
               banked_ms = add_saturated(banked_ms, elapsed_since_start(now));
               running = 1'b0;
            end else begin
               start_ms = now;
               running = 1'b1;
            end
            r = timer_readout(now, time_up);
         end
         FUNC_RESET: begin
            banked_ms = '0;
            running = 1'b0;
            start_ms = '0;
            r = timer_readout(now, time_up);
         end
         default: begin
            next_interval();
            r = timer_readout(now, time_up);
         end
      endcase
      expected_readouts.push_back(r);
   endfunction

   task automatic send_request(input func_type f, input logic [TIME_W-1:0] now);
      wbit_req_type item;
      item.func   = f;
      item.now_ms = now;
      req_ch.valid <= 1'b1;
      req_ch.data  <= item;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      apply_request(f, now);
      if (sender_gaps && burst_left == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
      end else if (burst_left != 0) begin
         burst_left--;
      end
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (expected_readouts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [DUR_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      case (index)
         CSR_WORK:  work_ms = value;
         CSR_SHORT: short_ms = value;
         CSR_LONG:  long_ms = value;
         default:   ;
      endcase
   endtask

   task automatic set_durations(input logic [DUR_W-1:0] work, input logic [DUR_W-1:0] brk,
                                input logic [DUR_W-1:0] long_brk);
      wait_idle();
      write_register(CSR_WORK, work);
      write_register(CSR_SHORT, brk);
      write_register(CSR_LONG, long_brk);
   endtask

   task automatic test_run_pause();
      send_request(FUNC_TICK, 0);
      send_request(FUNC_TOGGLE, 0);
      send_request(FUNC_TICK, 999);
      send_request(FUNC_TOGGLE, 60000);
      send_request(FUNC_TICK, 30000);
      send_request(FUNC_TOGGLE, 70000);
      send_request(FUNC_TICK, 50000);
      send_request(FUNC_RESET, 80000);
   endtask

   task automatic test_expiry_and_skip();
      send_request(FUNC_SKIP, 80000);
      send_request(FUNC_TOGGLE, 90000);
      send_request(FUNC_TICK, 390000);
      send_request(FUNC_TICK, 390000);
      repeat (5) send_request(FUNC_SKIP, 400000);
      send_request(FUNC_TOGGLE, 1000000);
      send_request(FUNC_TICK, 1900000);
   endtask

   task automatic test_time_extremes();
      send_request(FUNC_TOGGLE, 0);
      send_request(FUNC_TOGGLE, TIME_MAX);
      send_request(FUNC_TOGGLE, 1);
      send_request(FUNC_TICK, TIME_MAX);
      send_request(FUNC_SKIP, TIME_MAX);
   endtask

   task automatic test_duration_extremes();
      set_durations('0, DUR_MAX, DUR_W'(MS_PER_SEC));
      write_register(CSR_SPARE, DUR_W'($urandom));
      send_request(FUNC_TOGGLE, 5);
      send_request(FUNC_TICK, 6);
      send_request(FUNC_SKIP, 6);
      send_request(FUNC_SKIP, 6);
      send_request(FUNC_TOGGLE, 6);
      send_request(FUNC_TICK, TIME_W'(6 + DUR_MAX));
   endtask

   task automatic test_random_phase(input int count, input logic [DUR_W-1:0] work,
                                    input logic [DUR_W-1:0] brk,
                                    input logic [DUR_W-1:0] long_brk,
                                    input logic [TIME_W-1:0] base);
      logic [TIME_W-1:0] clock_ms;
      logic [TIME_W-1:0] stamp;
      logic [TIME_W:0]   next_ms;
      int                longest;
      int                pick;
      func_type          f;
      set_durations(work, brk, long_brk);
      longest = int'(work);
      if (int'(brk) > longest) longest = int'(brk);
      if (int'(long_brk) > longest) longest = int'(long_brk);
      clock_ms = base;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if ($urandom_range(0, 3) == 0)
            next_ms = {1'b0, clock_ms} +
                      (TIME_W+1)'($urandom_range(0, longest + MS_PER_SEC));
         else
            next_ms = {1'b0, clock_ms} + (TIME_W+1)'($urandom_range(0, 1500));
         clock_ms = next_ms[TIME_W] ? TIME_MAX : next_ms[TIME_W-1:0];
         stamp = clock_ms;
         if (pick < 55) begin
            f = FUNC_TICK;
         end else if (pick < 75) begin
            f = FUNC_TOGGLE;
         end else if (pick < 81) begin
            f = FUNC_RESET;
         end else if (pick < 90) begin
            f = FUNC_SKIP;
         end else begin
            f = func_type'($urandom_range(0, 3));
            stamp = {16'($urandom), $urandom};
            if (pick >= 95)
               clock_ms = stamp;
         end
         send_request(f, stamp);
      end
   endtask

   task automatic test_output_stall();
      int i;
      set_durations(2000, 1000, 3000);
      hold_left <= HOLD_CYCLES;
      sender_gaps = 1'b0;
      send_request(FUNC_TOGGLE, 0);
      for (i = 1; i < 40; i++)
         send_request((i % 7 == 0) ? FUNC_TOGGLE : FUNC_TICK, TIME_W'(i * 300));
      sender_gaps = 1'b1;
      wait_idle();
   endtask

   initial begin
      reset        = 1'b1;
      csr_wr_en    = 1'b0;
      csr_index    = CSR_WORK;
      csr_wdata    = '0;
      req_ch.valid = 1'b0;
      req_ch.data  = '0;
      rsp_ch.ready = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_run_pause();
      test_expiry_and_skip();
      test_time_extremes();
      test_duration_extremes();
      test_random_phase(85, 1000, 1000, 2000, '0);
      test_random_phase(85, DUR_W'($urandom_range(1000, 30000)),
                        DUR_W'($urandom_range(1000, 30000)),
                        DUR_W'($urandom_range(1000, 30000)), {16'd0, $urandom});
      test_random_phase(85, '0, DUR_MAX, 1, {16'($urandom), $urandom});
      test_random_phase(85, WORK_RESET, SHORT_RESET, LONG_RESET,
                        {16'($urandom_range(0, 255)), $urandom});
      test_output_stall();
      wait_idle();
      if (mismatch_count == 0 && expected_readouts.size() == 0)
         $display("** work_break_interval_timer: PASSED **");
      else
         $display("** work_break_interval_timer: FAILED **");
      $finish;
   end

endmodule
